### src/lps_pkg.sv
// shared types, codes and the sieve microprogram for the linear prime sieve
// no dependencies; used by lps_sieve_core and linear_prime_sieve

package lps_pkg;

   // result and table entry width, count ceiling, microprogram counter width
   localparam int VAL_W     = 16;
   localparam int COUNT_MAX = 16383;
   localparam int UPC_W     = 4;

   // request operation codes (code 3 is unused and answers with an error)
   typedef enum logic [1:0] {
      OP_RUN    = 2'd0,
      OP_FACTOR = 2'd1,
      OP_PRIME  = 2'd2
   } lps_op_type;

   // factor table port actions
   typedef enum logic [2:0] {
      FAC_NOP,
      FAC_CLEAR,
      FAC_ONE,
      FAC_READ,
      FAC_MARK
   } lps_fac_op_type;

   // walk counter actions
   typedef enum logic [1:0] {
      IOP_HOLD,
      IOP_ZERO,
      IOP_INC,
      IOP_TWO
   } lps_i_op_type;

   // prime list cursor actions
   typedef enum logic [1:0] {
      KOP_HOLD,
      KOP_ZERO,
      KOP_INC
   } lps_k_op_type;

   // jump conditions
   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_I_LT_N,
      CND_I_GT_N,
      CND_K_EQ_TOP,
      CND_PROD_GT_N,
      CND_P_NE_SPF
   } lps_cond_type;

   // one control word of the microprogram
   typedef struct packed {
      lps_fac_op_type   fac_op;
      logic             pl_read;
      lps_i_op_type     i_op;
      lps_k_op_type     k_op;
      logic             top_clear;
      logic             append;
      logic             load_spf;
      logic             load_mul;
      logic             finish;
      lps_cond_type     cond;
      logic [UPC_W-1:0] target;
   } lps_uword_type;

   // requests from the front end to the sieve core
   typedef struct packed {
      logic run_start;
      logic fac_query;
      logic pl_query;
   } lps_cmd_type;

   // microprogram step addresses
   localparam logic [UPC_W-1:0] UA_INIT   = 4'd0;
   localparam logic [UPC_W-1:0] UA_CLEAR  = 4'd1;
   localparam logic [UPC_W-1:0] UA_ONE    = 4'd2;
   localparam logic [UPC_W-1:0] UA_LOOP_I = 4'd3;
   localparam logic [UPC_W-1:0] UA_TEST   = 4'd4;
   localparam logic [UPC_W-1:0] UA_LOOP_K = 4'd5;
   localparam logic [UPC_W-1:0] UA_MUL    = 4'd6;
   localparam logic [UPC_W-1:0] UA_CHECK  = 4'd7;
   localparam logic [UPC_W-1:0] UA_MARK   = 4'd8;
   localparam logic [UPC_W-1:0] UA_NEXT_I = 4'd9;
   localparam logic [UPC_W-1:0] UA_END    = 4'd10;

   // microprogram rom: a jump is taken when its condition holds, else fall through
   function automatic lps_uword_type lps_ucode(input logic [UPC_W-1:0] upc);
      lps_uword_type w;
      w = '0;
      case (upc)
         UA_INIT: begin
            w.i_op      = IOP_ZERO;
            w.top_clear = 1'b1;
         end
         UA_CLEAR: begin
            w.fac_op = FAC_CLEAR;
            w.i_op   = IOP_INC;
            w.cond   = CND_I_LT_N;
            w.target = UA_CLEAR;
         end
         UA_ONE: begin
            w.fac_op = FAC_ONE;
            w.i_op   = IOP_TWO;
         end
         UA_LOOP_I: begin
            w.fac_op = FAC_READ;
            w.cond   = CND_I_GT_N;
            w.target = UA_END;
         end
         UA_TEST: begin
            w.load_spf = 1'b1;
            w.append   = 1'b1;
            w.k_op     = KOP_ZERO;
         end
         UA_LOOP_K: begin
            w.pl_read = 1'b1;
            w.cond    = CND_K_EQ_TOP;
            w.target  = UA_NEXT_I;
         end
         UA_MUL: begin
            w.load_mul = 1'b1;
         end
         UA_CHECK: begin
            w.cond   = CND_PROD_GT_N;
            w.target = UA_NEXT_I;
         end
         UA_MARK: begin
            w.fac_op = FAC_MARK;
            w.k_op   = KOP_INC;
            w.cond   = CND_P_NE_SPF;
            w.target = UA_LOOP_K;
         end
         UA_NEXT_I: begin
            w.i_op   = IOP_INC;
            w.cond   = CND_ALWAYS;
            w.target = UA_LOOP_I;
         end
         default: begin
            w.finish = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

### src/lps_sieve_core.sv
// microcoded sieve engine: sequencer, datapath, factor table and prime list
// depends on lps_pkg

module lps_sieve_core #(
   parameter int MAX_LIMIT      = 65535,
   parameter int PRIME_CAPACITY = 8192,
   localparam int NUM_W   = $clog2(MAX_LIMIT + 1),
   localparam int CAP_EFF = (PRIME_CAPACITY < lps_pkg::COUNT_MAX) ?
                            PRIME_CAPACITY : lps_pkg::COUNT_MAX,
   localparam int CNT_W   = $clog2(CAP_EFF + 1),
   localparam int PL_W    = (CAP_EFF > 1) ? $clog2(CAP_EFF) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lps_pkg::lps_cmd_type     cmd,
   input  logic [NUM_W-1:0]         run_n,
   input  logic [NUM_W-1:0]         fac_qaddr,
   input  logic [PL_W-1:0]          pl_qaddr,
   output logic                     run_done,
   output logic [NUM_W-1:0]         sieved_n,
   output logic [CNT_W-1:0]         prime_count,
   output logic [lps_pkg::VAL_W-1:0] fac_data,
   output logic [lps_pkg::VAL_W-1:0] pl_data
);

   localparam int I_W       = NUM_W + 1;
   localparam int VW        = lps_pkg::VAL_W;
   localparam int UW        = lps_pkg::UPC_W;
   localparam int PROD_W    = VW + I_W;
   localparam int FAC_DEPTH = MAX_LIMIT + 1;

   // sequencer and control registers
   logic                      running_ff, running_in;
   logic [lps_pkg::UPC_W-1:0] upc_ff, upc_in;
   logic                      done_ff, done_in;
   logic [NUM_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          top_ff, top_in;

   // datapath registers
   logic [I_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [VW-1:0]     spf_ff, spf_in;
   logic [VW-1:0]     p_ff, p_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // memories and their ports
   logic [VW-1:0]    fac_mem [FAC_DEPTH];
   logic [VW-1:0]    pl_mem [CAP_EFF];
   logic [VW-1:0]    fac_rd_ff;
   logic [VW-1:0]    pl_rd_ff;
   logic             fac_we, fac_re;
   logic [NUM_W-1:0] fac_waddr, fac_raddr;
   logic [VW-1:0]    fac_wdata;
   logic             pl_we, pl_re;
   logic [PL_W-1:0]  pl_waddr, pl_raddr;

   lps_pkg::lps_uword_type uw;
   logic i_lt_n, i_gt_n, k_eq_top, prod_gt_n, p_ne_spf;
   logic cond_true, is_prime, list_open, append_en;

   // control word for the current step
   assign uw = lps_pkg::lps_ucode(upc_ff);

   // datapath flags
   assign i_lt_n    = i_ff < I_W'(n_ff);
   assign i_gt_n    = i_ff > I_W'(n_ff);
   assign k_eq_top  = k_ff == top_ff;
   assign prod_gt_n = prod_ff > PROD_W'(n_ff);
   assign p_ne_spf  = p_ff != spf_ff;
   assign is_prime  = fac_rd_ff == '0;
   assign list_open = top_ff < CNT_W'(CAP_EFF);
   assign append_en = running_ff && uw.append && is_prime && list_open;

   // jump condition select
   always_comb begin
      case (uw.cond)
         lps_pkg::CND_ALWAYS:    cond_true = 1'b1;
         lps_pkg::CND_I_LT_N:    cond_true = i_lt_n;
         lps_pkg::CND_I_GT_N:    cond_true = i_gt_n;
         lps_pkg::CND_K_EQ_TOP:  cond_true = k_eq_top;
         lps_pkg::CND_PROD_GT_N: cond_true = prod_gt_n;
         lps_pkg::CND_P_NE_SPF:  cond_true = p_ne_spf;
         default:                cond_true = 1'b0;
      endcase
   end

   // factor table port: sequencer while running, query port otherwise
   always_comb begin
      fac_we    = 1'b0;
      fac_waddr = i_ff[NUM_W-1:0];
      fac_wdata = '0;
      fac_re    = 1'b0;
      fac_raddr = fac_qaddr;
      if (running_ff) begin
         case (uw.fac_op)
            lps_pkg::FAC_CLEAR: begin
               fac_we = 1'b1;
            end
            lps_pkg::FAC_ONE: begin
               fac_we    = 1'b1;
               fac_waddr = NUM_W'(1);
               fac_wdata = VW'(1);
            end
            lps_pkg::FAC_READ: begin
               fac_re    = !i_gt_n;
               fac_raddr = i_ff[NUM_W-1:0];
            end
            lps_pkg::FAC_MARK: begin
               fac_we    = 1'b1;
               fac_waddr = prod_ff[NUM_W-1:0];
               fac_wdata = p_ff;
            end
            default: begin
            end
         endcase
      end else begin
         fac_re = cmd.fac_query;
      end
   end

   // prime list port: append at the top, read at the cursor or the query index
   always_comb begin
      pl_we    = append_en;
      pl_waddr = top_ff[PL_W-1:0];
      if (running_ff) begin
         pl_re    = uw.pl_read && !k_eq_top;
         pl_raddr = k_ff[PL_W-1:0];
      end else begin
         pl_re    = cmd.pl_query;
         pl_raddr = pl_qaddr;
      end
   end

   // memory arrays with registered read data
   always_ff @(posedge clock) begin
      if (fac_we) begin
         fac_mem[fac_waddr] <= fac_wdata;
      end
      if (fac_re) begin
         fac_rd_ff <= fac_mem[fac_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         pl_mem[pl_waddr] <= VW'(i_ff);
      end
      if (pl_re) begin
         pl_rd_ff <= pl_mem[pl_raddr];
      end
   end

   // next values of sequencer and datapath
   always_comb begin
      running_in = running_ff;
      upc_in     = upc_ff;
      done_in    = 1'b0;
      n_in       = n_ff;
      top_in     = top_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      spf_in     = spf_ff;
      p_in       = p_ff;
      prod_in    = prod_ff;
      if (running_ff) begin
         case (uw.i_op)
            lps_pkg::IOP_ZERO: i_in = '0;
            lps_pkg::IOP_INC:  i_in = i_ff + I_W'(1);
            lps_pkg::IOP_TWO:  i_in = I_W'(2);
            default:           i_in = i_ff;
         endcase
         case (uw.k_op)
            lps_pkg::KOP_ZERO: k_in = '0;
            lps_pkg::KOP_INC:  k_in = k_ff + CNT_W'(1);
            default:           k_in = k_ff;
         endcase
         if (uw.top_clear) begin
            top_in = '0;
         end else if (append_en) begin
            top_in = top_ff + CNT_W'(1);
         end
         // smallest factor of i: i itself when its entry is still clear
         if (uw.load_spf) begin
            spf_in = is_prime ? VW'(i_ff) : fac_rd_ff;
         end
         if (uw.load_mul) begin
            p_in    = pl_rd_ff;
            prod_in = PROD_W'(pl_rd_ff) * PROD_W'(i_ff);
         end
         if (uw.finish) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            upc_in = cond_true ? uw.target : upc_ff + UW'(1);
         end
      end else if (cmd.run_start) begin
         running_in = 1'b1;
         upc_in     = lps_pkg::UA_INIT;
         n_in       = run_n;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         upc_ff     <= lps_pkg::UA_INIT;
         done_ff    <= 1'b0;
         n_ff       <= '0;
         top_ff     <= '0;
      end else begin
         running_ff <= running_in;
         upc_ff     <= upc_in;
         done_ff    <= done_in;
         n_ff       <= n_in;
         top_ff     <= top_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      k_ff    <= k_in;
      spf_ff  <= spf_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
   end

   assign run_done    = done_ff;
   assign sieved_n    = n_ff;
   assign prime_count = top_ff;
   assign fac_data    = fac_rd_ff;
   assign pl_data     = pl_rd_ff;

endmodule

### src/linear_prime_sieve.sv
// linear prime sieve: request decode, range checks and result register
// depends on lps_pkg and lps_sieve_core
//
// usage
//   req_ carries one beat per item: req_operation selects run (limit in req_limit),
//   factor read or prime read (both use req_index). rsp_ returns exactly one beat
//   per item: rsp_value and rsp_status (1 when the index lies outside the last
//   run or the operation code is unused). one item is handled at a time;
//   req_stall is high from acceptance until the result has been loaded into the
//   output register. queries: the table read data is registered at the accepting
//   edge and loaded into the output register from the finishing state.
//   run with limit n: the microprogram walks the single factor table port: it
//   clears entries 0 to n, then for each number from 2 to n reads its entry,
//   walks the prime list and marks p times the number for listed primes p up to its smallest factor.
//   reset clears the sequencer, the prime count and the sieved limit; table
//   contents are not cleared, queries before a run report status 1.
//   while rsp_stall is high the result holds in the output register and a
//   finished item waits in its finishing state until the register frees.

module linear_prime_sieve #(
   parameter int MAX_LIMIT      = 65535,
   parameter int PRIME_CAPACITY = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_limit,
   input  logic [15:0] req_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_value,
   output logic        rsp_status
);

   localparam int NUM_W   = $clog2(MAX_LIMIT + 1);
   localparam int CAP_EFF = (PRIME_CAPACITY < lps_pkg::COUNT_MAX) ?
                            PRIME_CAPACITY : lps_pkg::COUNT_MAX;
   localparam int CNT_W   = $clog2(CAP_EFF + 1);
   localparam int PL_W    = (CAP_EFF > 1) ? $clog2(CAP_EFF) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_COUNT,
      SRC_FACTOR,
      SRC_PRIME,
      SRC_ERROR
   } src_type;

   state_type   state_ff, state_in;
   src_type     src_ff, src_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic        rsp_status_ff, rsp_status_in;

   lps_pkg::lps_cmd_type cmd;
   logic [31:0]          lim_wide, lim_sat, idx_wide;
   logic [NUM_W-1:0]     run_n;
   logic                 run_done;
   logic [NUM_W-1:0]     sieved_n;
   logic [CNT_W-1:0]     prime_count;
   logic [15:0]          fac_data, pl_data, sel_value;
   logic                 fac_in_range, pl_in_range, out_free;

   // limit saturation and query range checks
   always_comb begin
      lim_wide = {16'd0, req_limit};
      idx_wide = {16'd0, req_index};
      if (lim_wide == 32'd0) begin
         lim_sat = 32'd1;
      end else if (lim_wide > 32'(MAX_LIMIT)) begin
         lim_sat = 32'(MAX_LIMIT);
      end else begin
         lim_sat = lim_wide;
      end
      run_n        = NUM_W'(lim_sat);
      fac_in_range = (sieved_n != '0) && (idx_wide <= 32'(sieved_n));
      pl_in_range  = idx_wide < 32'(prime_count);
   end

   lps_sieve_core #(
      .MAX_LIMIT      (MAX_LIMIT),
      .PRIME_CAPACITY (PRIME_CAPACITY)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .run_n       (run_n),
      .fac_qaddr   (NUM_W'(idx_wide)),
      .pl_qaddr    (req_index[PL_W-1:0]),
      .run_done    (run_done),
      .sieved_n    (sieved_n),
      .prime_count (prime_count),
      .fac_data    (fac_data),
      .pl_data     (pl_data)
   );

   // result source select
   always_comb begin
      case (src_ff)
         SRC_COUNT:  sel_value = 16'(prime_count);
         SRC_FACTOR: sel_value = fac_data;
         SRC_PRIME:  sel_value = pl_data;
         default:    sel_value = '0;
      endcase
   end

   // request decode and result hand-off
   always_comb begin
      req_stall     = state_ff != ST_IDLE;
      out_free      = !rsp_valid_ff || !rsp_stall;
      cmd           = '0;
      state_in      = state_ff;
      src_in        = src_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               case (req_operation)
                  lps_pkg::OP_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = ST_RUN;
                  end
                  lps_pkg::OP_FACTOR: begin
                     cmd.fac_query = fac_in_range;
                     src_in        = fac_in_range ? SRC_FACTOR : SRC_ERROR;
                  end
                  lps_pkg::OP_PRIME: begin
                     cmd.pl_query = pl_in_range;
                     src_in       = pl_in_range ? SRC_PRIME : SRC_ERROR;
                  end
                  default: begin
                     src_in = SRC_ERROR;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (run_done) begin
               src_in   = SRC_COUNT;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = sel_value;
               rsp_status_in = src_ff == SRC_ERROR;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= SRC_ERROR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   // a new result beat is only loaded from the finishing state
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared outside the finishing state");

   // the sieve core only finishes a run that the front end is waiting on
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      run_done |-> state_ff == ST_RUN)
      else $error("sieve run finished while no run was pending");

   // an out-of-range answer always carries a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> rsp_value_ff == 16'd0)
      else $error("error result with nonzero value");

   // a run request starts the sequencer on the next cycle
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation == lps_pkg::OP_RUN)
      |=> state_ff == ST_RUN)
      else $error("run request did not start the sieve");
`endif

endmodule
